// ===== sv/qmp_pkg.sv =====
package qmp_pkg;

   localparam int MAX_DOFS  = 64;
   localparam int MAX_MODES = 8;

   typedef enum logic [3:0] {
      OP_MEAN     = 4'd0,
      OP_LINEAR   = 4'd1,
      OP_QUAD     = 4'd2,
      OP_COORD    = 4'd3,
      OP_DIR      = 4'd4,
      OP_FORCE    = 4'd5,
      OP_DECODE   = 4'd6,
      OP_APPLY    = 4'd7,
      OP_PROJECT  = 4'd8
   } op_type;

   localparam logic CSR_MODES = 1'b0;
   localparam logic CSR_DOFS  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      D_MR, D_ML,
      D_LR, D_LM, D_LA,
      D_QI, D_QJ, D_FM, D_FR, D_QM, D_QA,
      J_BR, J_BL, J_TR, J_TM, J_TA1, J_TA2, J_JR, J_JM, J_JA,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } red_type;

endpackage

// ===== sv/quadratic_manifold_projector_top.sv =====
// Quadratic manifold decoder / projector.
// Input words enter on start while busy is low. Load words (mean, linear,
// quadratic, q, dq, force) write one store entry; busy stays low, so loads
// stream one per clock. Writes past the sizes in use are dropped.
// Compute words (decode, applyJ, projectForce) raise busy and walk the
// stores through one shared 32x32 multiplier and saturating 64-bit
// accumulators; every store read is registered.
//   decode:  n rows, each summing m linear and m^2 quadratic terms
//   applyJ:  n rows, each over m Jacobian entries
//   project: m modes, each over n rows of Jacobian entries
// Each result word is shown for one cycle with rsp_valid, registered, and
// rsp_last marks the final word. The receiver cannot stall.
// Configuration (modes, dofs) is written on csr_valid, csr_ready is always
// high; write only while busy is low.
// Reset (synchronous) returns to idle with m = MAX_MODES, n = MAX_DOFS;
// store contents are undefined until written.
module quadratic_manifold_projector_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_operation,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [5:0]         rsp_out_index,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_saturated,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import qmp_pkg::*;

   localparam int MODES_SQ = MAX_MODES * MAX_MODES;
   localparam int DW  = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
   localparam int MW  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int QCW = (MODES_SQ > 1) ? $clog2(MODES_SQ) : 1;
   localparam int LAW = (MAX_DOFS * MAX_MODES > 1) ? $clog2(MAX_DOFS * MAX_MODES) : 1;
   localparam int QAW = (MAX_DOFS * MODES_SQ > 1) ? $clog2(MAX_DOFS * MODES_SQ) : 1;
   localparam int MCW = $clog2(MAX_MODES + 1);
   localparam int NCW = $clog2(MAX_DOFS + 1);

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s;
   endfunction

   function automatic red_type reduce(input logic signed [63:0] a, input int s);
      logic signed [63:0] t;
      red_type r;
      t = sat_add(a, 64'sd1 <<< (s - 1));
      t = t >>> s;
      r.clip = 1'b1;
      if (t > 64'sd2147483647)       r.value = 32'sh7fffffff;
      else if (t < -64'sd2147483648) r.value = 32'sh80000000;
      else begin
         r.value = t[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   // stores
   logic signed [31:0] mean_mem  [MAX_DOFS];
   logic signed [31:0] lin_mem   [MAX_DOFS * MAX_MODES];
   logic signed [31:0] quad_mem  [MAX_DOFS * MODES_SQ];
   logic signed [31:0] coord_mem [MAX_MODES];
   logic signed [31:0] dir_mem   [MAX_MODES];
   logic signed [31:0] force_mem [MAX_DOFS];
   logic signed [31:0] mean_rd, lin_rd, quad_rd, coord_rd, dir_rd, force_rd;

   logic [3:0] modes_ff;
   logic [6:0] dofs_ff;
   logic [MCW-1:0] m;
   logic [NCW-1:0] n;
   logic [QCW:0] m_sq;

   state_type state_ff, state_in;
   op_type op_ff;
   logic [DW-1:0] r_ff;
   logic [MW-1:0] k_ff, i_ff, j_ff;
   logic [QCW-1:0] kbase_ff, ca_ff, cb_ff;
   logic signed [63:0] acc_ff, accj_ff, prod_ff;
   logic signed [31:0] hold_ff, hold2_ff, f_ff;
   logic clip_ff;

   logic [DW-1:0] mean_addr, force_addr;
   logic [LAW-1:0] lin_addr;
   logic [QAW-1:0] quad_addr;
   logic [MW-1:0] coord_addr, dir_addr;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   red_type red_f, red_j, red_o;
   logic r_end, k_end, i_end, j_end;
   logic accept;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;

   always_comb begin
      if (modes_ff == 4'd0)                 m = MCW'(1);
      else if (int'(modes_ff) > MAX_MODES)  m = MCW'(MAX_MODES);
      else                                  m = MCW'(modes_ff);
      if (dofs_ff == 7'd0)                  n = NCW'(1);
      else if (int'(dofs_ff) > MAX_DOFS)    n = NCW'(MAX_DOFS);
      else                                  n = NCW'(dofs_ff);
      m_sq = (QCW + 1)'(int'(m) * int'(m));
   end

   assign r_end = (int'(r_ff) == int'(n) - 1);
   assign k_end = (int'(k_ff) == int'(m) - 1);
   assign i_end = (int'(i_ff) == int'(m) - 1);
   assign j_end = (int'(j_ff) == int'(m) - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= 4'(MAX_MODES);
         dofs_ff  <= 7'(MAX_DOFS);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODES: modes_ff <= csr_wdata[3:0];
            CSR_DOFS:  dofs_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // load writes
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_operation == OP_MEAN && int'(req_row_index) < int'(n))
            mean_mem[DW'(req_row_index)] <= req_value;
         if (req_operation == OP_LINEAR && int'(req_row_index) < int'(n)
             && int'(req_col_index) < int'(m))
            lin_mem[LAW'(int'(req_row_index) * MAX_MODES + int'(req_col_index))] <= req_value;
         if (req_operation == OP_QUAD && int'(req_row_index) < int'(n)
             && int'(req_col_index) < int'(m_sq))
            quad_mem[QAW'(int'(req_row_index) * MODES_SQ + int'(req_col_index))] <= req_value;
         if (req_operation == OP_COORD && int'(req_col_index) < int'(m))
            coord_mem[MW'(req_col_index)] <= req_value;
         if (req_operation == OP_DIR && int'(req_col_index) < int'(m))
            dir_mem[MW'(req_col_index)] <= req_value;
         if (req_operation == OP_FORCE && int'(req_row_index) < int'(n))
            force_mem[DW'(req_row_index)] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      mean_rd  <= mean_mem[mean_addr];
      lin_rd   <= lin_mem[lin_addr];
      quad_rd  <= quad_mem[quad_addr];
      coord_rd <= coord_mem[coord_addr];
      dir_rd   <= dir_mem[dir_addr];
      force_rd <= force_mem[force_addr];
   end

   // read addresses and multiplier operands
   always_comb begin
      mean_addr  = r_ff;
      force_addr = r_ff;
      dir_addr   = k_ff;
      lin_addr   = LAW'(int'(r_ff) * MAX_MODES + int'(k_ff));
      quad_addr  = QAW'(int'(r_ff) * MODES_SQ + int'(ca_ff));
      coord_addr = k_ff;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         D_QI:  coord_addr = i_ff;
         D_QJ:  coord_addr = j_ff;
         J_TR:  coord_addr = j_ff;
         J_TM:  quad_addr  = QAW'(int'(r_ff) * MODES_SQ + int'(cb_ff));
         D_LM: begin mul_a = lin_rd;   mul_b = coord_rd; end
         D_FM: begin mul_a = hold_ff;  mul_b = coord_rd; end
         D_QM: begin mul_a = hold2_ff; mul_b = f_ff;     end
         J_JM: begin
            mul_a = hold_ff;
            mul_b = (op_ff == OP_PROJECT) ? force_rd : dir_rd;
         end
         default: ;
      endcase
      if (state_ff == J_TM || state_ff == J_TA1) begin
         mul_a = quad_rd;
         mul_b = (state_ff == J_TM) ? coord_rd : hold_ff;
      end
   end

   assign mul_p = mul_a * mul_b;
   assign red_f = reduce(prod_ff, FRAC_BITS + 1);
   assign red_j = reduce(accj_ff, FRAC_BITS + 1);
   assign red_o = reduce(acc_ff, FRAC_BITS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_DECODE) state_in = D_MR;
               else if (req_operation == OP_APPLY || req_operation == OP_PROJECT)
                  state_in = J_BR;
            end
         end
         D_MR:  state_in = D_ML;
         D_ML:  state_in = D_LR;
         D_LR:  state_in = D_LM;
         D_LM:  state_in = D_LA;
         D_LA:  state_in = k_end ? D_QI : D_LR;
         D_QI:  state_in = D_QJ;
         D_QJ:  state_in = D_FM;
         D_FM:  state_in = D_FR;
         D_FR:  state_in = D_QM;
         D_QM:  state_in = D_QA;
         D_QA:  state_in = (i_end && j_end) ? S_OUT : D_QI;
         J_BR:  state_in = J_BL;
         J_BL:  state_in = J_TR;
         J_TR:  state_in = J_TM;
         J_TM:  state_in = J_TA1;
         J_TA1: state_in = J_TA2;
         J_TA2: state_in = j_end ? J_JR : J_TR;
         J_JR:  state_in = J_JM;
         J_JM:  state_in = J_JA;
         J_JA: begin
            if (op_ff == OP_PROJECT) state_in = r_end ? S_OUT : J_BR;
            else                     state_in = k_end ? S_OUT : J_BR;
         end
         S_OUT: begin
            if (op_ff == OP_PROJECT) state_in = k_end ? S_IDLE : J_BR;
            else if (r_end)          state_in = S_IDLE;
            else                     state_in = (op_ff == OP_DECODE) ? D_MR : J_BR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff    <= op_type'(req_operation);
            r_ff     <= '0;
            k_ff     <= '0;
            kbase_ff <= '0;
            acc_ff   <= '0;
            clip_ff  <= 1'b0;
         end
         D_ML: begin
            acc_ff <= 64'(mean_rd) <<< FRAC_BITS;
            k_ff   <= '0;
         end
         D_LM, J_TM, J_TA1, J_JM, D_QM, D_FM: prod_ff <= mul_p;
         D_LA: begin
            acc_ff <= sat_add(acc_ff, prod_ff);
            k_ff   <= k_ff + 1'b1;
            i_ff   <= '0;
            j_ff   <= '0;
            ca_ff  <= '0;
         end
         D_QJ:  hold_ff <= coord_rd;
         D_FR: begin
            f_ff    <= red_f.value;
            clip_ff <= clip_ff | red_f.clip;
         end
         D_QA: begin
            acc_ff <= sat_add(acc_ff, prod_ff);
            ca_ff  <= ca_ff + 1'b1;
            if (j_end) begin
               j_ff <= '0;
               i_ff <= i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         J_BL: begin
            accj_ff <= 64'(lin_rd) <<< (FRAC_BITS + 1);
            j_ff    <= '0;
            ca_ff   <= kbase_ff;
            cb_ff   <= QCW'(k_ff);
         end
         J_TA2: begin
            accj_ff <= sat_add(accj_ff, prod_ff);
            j_ff    <= j_ff + 1'b1;
            ca_ff   <= ca_ff + 1'b1;
            cb_ff   <= cb_ff + QCW'(m);
         end
         J_JR: begin
            hold_ff <= red_j.value;
            clip_ff <= clip_ff | red_j.clip;
         end
         J_JA: begin
            acc_ff <= sat_add(acc_ff, prod_ff);
            if (op_ff == OP_PROJECT) begin
               r_ff <= r_ff + 1'b1;
            end else begin
               k_ff     <= k_ff + 1'b1;
               kbase_ff <= kbase_ff + QCW'(m);
            end
         end
         S_OUT: begin
            acc_ff  <= '0;
            clip_ff <= 1'b0;
            if (op_ff == OP_PROJECT) begin
               r_ff     <= '0;
               k_ff     <= k_ff + 1'b1;
               kbase_ff <= kbase_ff + QCW'(m);
            end else begin
               r_ff     <= r_ff + 1'b1;
               k_ff     <= '0;
               kbase_ff <= '0;
            end
         end
         default: ;
      endcase
      // J_TA1 also folds in the first quadratic term
      if (state_ff == J_TA1) accj_ff <= sat_add(accj_ff, prod_ff);
      if (state_ff == J_TM)  hold_ff <= coord_rd;
      if (state_ff == D_FM)  hold2_ff <= quad_rd;
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= (state_ff == S_OUT);
      if (state_ff == S_OUT) begin
         rsp_out_value <= red_o.value;
         rsp_saturated <= clip_ff | red_o.clip;
         if (op_ff == OP_PROJECT) begin
            rsp_out_index <= 6'(k_ff);
            rsp_last      <= k_end;
         end else begin
            rsp_out_index <= 6'(r_ff);
            rsp_last      <= r_end;
         end
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import qmp_pkg::*;

   localparam int FRAC      = 16;
   localparam int PRE_ROWS  = 6;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [5:0]  index;
      logic [31:0] value;
      logic        sat;
      logic        last;
   } entry_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_operation;
   logic [5:0]  req_row_index;
   logic [5:0]  req_col_index;
   logic signed [31:0] req_value;
   logic        rsp_valid;
   logic [5:0]  rsp_out_index;
   logic signed [31:0] rsp_out_value;
   logic        rsp_saturated;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_wdata;

   quadratic_manifold_projector_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_out_index(rsp_out_index),
      .rsp_out_value(rsp_out_value), .rsp_saturated(rsp_saturated),
      .rsp_last(rsp_last), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the block's stores and sizes
   int mean_mem [MAX_DOFS];
   int lin_mem  [MAX_DOFS*MAX_MODES];
   int quad_mem [MAX_DOFS*MAX_MODES*MAX_MODES];
   int coord_mem[MAX_MODES];
   int dir_mem  [MAX_MODES];
   int force_mem[MAX_DOFS];
   logic [3:0] modes_reg;
   logic [6:0] dofs_reg;

   entry_type pending_words[$];
   int     errors;
   longint cycles;
   bit     gaps_on;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return a[63] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      return s;
   endfunction

   // round half up, shift, clip to 32 bits
   function automatic int reduce(longint acc, int s, inout bit clip);
      longint r;
      r = sadd(acc, 64'sd1 <<< (s - 1)) >>> s;
      if (r > 64'sd2147483647) begin
         clip = 1;
         return 32'h7FFFFFFF;
      end
      if (r < -64'sd2147483648) begin
         clip = 1;
         return 32'h80000000;
      end
      return int'(r);
   endfunction

   function automatic int modes_now();
      if (modes_reg < 1) return 1;
      if (modes_reg > MAX_MODES) return MAX_MODES;
      return modes_reg;
   endfunction

   function automatic int dofs_now();
      if (dofs_reg < 1) return 1;
      if (dofs_reg > MAX_DOFS) return MAX_DOFS;
      return dofs_reg;
   endfunction

   function automatic int jac(int r, int k, int m, inout bit clip);
      longint acc;
      acc = longint'(lin_mem[r*MAX_MODES+k]) <<< (FRAC + 1);
      for (int j = 0; j < m; j++) begin
         acc = sadd(acc, longint'(quad_mem[r*64+k*m+j]) * longint'(coord_mem[j]));
         acc = sadd(acc, longint'(quad_mem[r*64+j*m+k]) * longint'(coord_mem[j]));
      end
      return reduce(acc, FRAC + 1, clip);
   endfunction

   function automatic void push_word(int idx, int v, bit clip, bit last);
      entry_type e;
      e.index = idx[5:0];
      e.value = v;
      e.sat   = clip;
      e.last  = last;
      pending_words.push_back(e);
   endfunction

   function automatic void predict(logic [3:0] op, int row, int col, int val);
      int m, n, f, v;
      bit clip;
      longint acc;
      m = modes_now();
      n = dofs_now();
      case (op)
         OP_MEAN:   if (row < n) mean_mem[row] = val;
         OP_LINEAR: if (row < n && col < m) lin_mem[row*MAX_MODES+col] = val;
         OP_QUAD:   if (row < n && col < m*m) quad_mem[row*64+col] = val;
         OP_COORD:  if (col < m) coord_mem[col] = val;
         OP_DIR:    if (col < m) dir_mem[col] = val;
         OP_FORCE:  if (row < n) force_mem[row] = val;
         OP_DECODE:
            for (int r = 0; r < n; r++) begin
               clip = 0;
               acc = longint'(mean_mem[r]) <<< FRAC;
               for (int k = 0; k < m; k++)
                  acc = sadd(acc, longint'(lin_mem[r*MAX_MODES+k]) * longint'(coord_mem[k]));
               for (int i = 0; i < m; i++)
                  for (int j = 0; j < m; j++) begin
                     f = reduce(longint'(coord_mem[i]) * longint'(coord_mem[j]),
                                FRAC + 1, clip);
                     acc = sadd(acc, longint'(quad_mem[r*64+i*m+j]) * longint'(f));
                  end
               v = reduce(acc, FRAC, clip);
               push_word(r, v, clip, r + 1 == n);
            end
         OP_APPLY:
            for (int r = 0; r < n; r++) begin
               clip = 0;
               acc = 0;
               for (int k = 0; k < m; k++)
                  acc = sadd(acc, longint'(jac(r, k, m, clip)) * longint'(dir_mem[k]));
               v = reduce(acc, FRAC, clip);
               push_word(r, v, clip, r + 1 == n);
            end
         OP_PROJECT:
            for (int k = 0; k < m; k++) begin
               clip = 0;
               acc = 0;
               for (int r = 0; r < n; r++)
                  acc = sadd(acc, longint'(jac(r, k, m, clip)) * longint'(force_mem[r]));
               v = reduce(acc, FRAC, clip);
               push_word(k, v, clip, k + 1 == m);
            end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      entry_type e;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word idx=%0d value=%h", $time, rsp_out_index,
                     rsp_out_value);
            errors++;
         end else begin
            e = pending_words.pop_front();
            if (rsp_out_index !== e.index || rsp_out_value !== e.value ||
                rsp_saturated !== e.sat || rsp_last !== e.last) begin
               $display("%0t: mismatch expected idx=%0d val=%h sat=%b last=%b", $time,
                        e.index, e.value, e.sat, e.last);
               $display("%0t:          actual   idx=%0d val=%h sat=%b last=%b", $time,
                        rsp_out_index, rsp_out_value, rsp_saturated, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic int pick_value();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom;
         default: return int'($urandom_range(0, 'h3FFFF)) - 'h20000;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge with start still high
   task automatic send_word(logic [3:0] op, int row, int col, int val);
      if (gaps_on && $urandom_range(99) < 36) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start         <= 1;
      req_operation <= op;
      req_row_index <= row[5:0];
      req_col_index <= col[5:0];
      req_value     <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict(op, row & 63, col & 63, val);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (pending_words.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] data);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      if (idx == CSR_MODES) modes_reg = data[3:0];
      else dofs_reg = data[6:0];
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_sizes(int m, int n);
      write_csr(CSR_MODES, 32'({$urandom, 4'b0}) | 32'(m & 15));
      write_csr(CSR_DOFS, 32'({$urandom, 7'b0}) | 32'(n & 127));
   endtask

   // row 0 is filled for every mode count, rows below PRE_ROWS for two modes;
   // later computes stay inside what is written here
   task automatic test_preload();
      set_sizes(MAX_MODES, MAX_DOFS);
      for (int r = 0; r < PRE_ROWS; r++) begin
         send_word(OP_MEAN, r, 0, pick_value());
         send_word(OP_FORCE, r, 0, pick_value());
         for (int k = 0; k < ((r == 0) ? MAX_MODES : 2); k++)
            send_word(OP_LINEAR, r, k, pick_value());
         for (int c = 0; c < ((r == 0) ? 64 : 4); c++)
            send_word(OP_QUAD, r, c, pick_value());
      end
      for (int k = 0; k < MAX_MODES; k++) begin
         send_word(OP_COORD, 0, k, pick_value());
         send_word(OP_DIR, 0, k, pick_value());
      end
      drain();
   endtask

   task automatic test_directed();
      set_sizes(MAX_MODES, 1);
      send_word(OP_COORD, 63, 7, 32'h7FFFFFFF);
      send_word(OP_DIR, 0, 0, 32'h80000000);
      send_word(OP_LINEAR, 0, 7, 32'h7FFFFFFF);
      send_word(OP_QUAD, 0, 63, 32'h80000000);
      send_word(OP_MEAN, 0, 63, 32'h7FFFFFFF);
      send_word(OP_FORCE, 0, 63, 32'h80000000);
      // row past the size in use is dropped
      send_word(OP_LINEAR, 63, 7, 5);
      send_word(OP_DECODE, 0, 0, 0);
      send_word(OP_APPLY, 63, 63, -1);
      send_word(OP_PROJECT, 0, 0, 0);
      // unknown codes give nothing
      for (int c = OP_PROJECT + 1; c <= 15; c++) send_word(c[3:0], 63, 63, -1);
      drain();
      // out-of-range sizes clamp; writes past the sizes are dropped
      set_sizes(0, 0);
      send_word(OP_LINEAR, 1, 0, 5);
      send_word(OP_COORD, 0, 1, 5);
      send_word(OP_QUAD, 0, 1, 5);
      send_word(OP_MEAN, 0, 0, 32'h00010000);
      send_word(OP_DECODE, 0, 0, 0);
      send_word(OP_APPLY, 0, 0, 0);
      send_word(OP_PROJECT, 0, 0, 0);
      set_sizes(15, 1);
      send_word(OP_PROJECT, 0, 0, 0);
   endtask

   task automatic random_phase(int m, int n, int count, int pct_compute);
      int mm, nn, op, row, col;
      set_sizes(m, n);
      mm = modes_now();
      nn = dofs_now();
      repeat (count) begin
         if ($urandom_range(99) < pct_compute) op = $urandom_range(OP_DECODE, OP_PROJECT);
         else if ($urandom_range(49) == 0) op = $urandom_range(OP_PROJECT + 1, 15);
         else op = $urandom_range(OP_MEAN, OP_FORCE);
         if ($urandom_range(9) == 0) begin
            row = $urandom_range(63);
            col = $urandom_range(63);
         end else begin
            row = $urandom_range(nn - 1);
            col = $urandom_range((op == OP_QUAD) ? mm*mm - 1 : mm - 1);
         end
         send_word(op[3:0], row, col, pick_value());
      end
   endtask

   task automatic test_random();
      random_phase(1, 1, 15, 20);
      random_phase(8, 1, 15, 20);
      random_phase(1, PRE_ROWS, 15, 10);
      gaps_on = 0;
      random_phase(2, 5, 25, 20);
      gaps_on = 1;
      for (int p = 0; p < 2; p++)
         random_phase($urandom_range(1, 2), $urandom_range(1, PRE_ROWS), 15, 20);
      drain();
   endtask

   initial begin
      errors        = 0;
      cycles        = 0;
      gaps_on       = 1;
      modes_reg     = MAX_MODES;
      dofs_reg      = MAX_DOFS;
      reset         = 1;
      start         = 0;
      req_operation = OP_MEAN;
      req_row_index = 0;
      req_col_index = 0;
      req_value     = 0;
      csr_valid     = 0;
      csr_index     = CSR_MODES;
      csr_wdata     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_preload();
      test_directed();
      test_random();
      repeat (20) @(negedge clock);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
